/* hdl/lbc_pkg.sv */
// Shared constants for the LZW byte compressor.
// No dependencies; used by every module of the block.
package lbc_pkg;

  localparam int CODE_BITS_DEF = 12;
  localparam int BYTE_BITS     = 8;
  localparam int EPOCH_BITS    = 8;
  localparam int FIRST_FREE    = 256;

endpackage

/* hdl/lzw_byte_compressor_core.sv */
// LZW byte compressor top level: stream handshake, lookup sequencer, output stage.
// Depends on lbc_pkg and lbc_ram (hashed dictionary in one synchronous RAM).
//
//  channel | signals                         | payload
//  --------+---------------------------------+--------------------------------
//  input   | in_tvalid  in_tready  in_tlast  | tdata = data_byte, tlast = final_byte
//  output  | out_tvalid out_tready out_tlast | tdata = out_code (zero padded),
//          |                                 | tlast = last_code
//
// A byte that starts a stream is taken in the idle state alone; one that probes the dictionary
// also passes the compare state, plus an extra probe per hash collision and an emit step per result.
// The RAM read port reads one slot per cycle and registers its read data.
// After reset, and after every 2^EPOCH_BITS-1 streams, a clearing pass over all
// 2^(CODE_BITS+1) slots sweeps the RAM while in_tready stays low.
// A stalled output holds one result; the next request is taken meanwhile.
module lzw_byte_compressor_core #(
  parameter int CODE_BITS = lbc_pkg::CODE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lbc_pkg::BYTE_BITS-1:0]         in_tdata,   // [7:0] data_byte
  input  logic                                  in_tlast,   // final_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((CODE_BITS+7)/8)*8-1:0]        out_tdata,  // [CODE_BITS-1:0] out_code
  output logic                                  out_tlast   // last_code
);

  localparam int BW     = lbc_pkg::BYTE_BITS;
  localparam int EW     = lbc_pkg::EPOCH_BITS;
  localparam int AW     = CODE_BITS + 1;
  localparam int DEPTH  = 1 << AW;
  localparam int SLOT_W = EW + CODE_BITS + BW + CODE_BITS;
  localparam int OUT_W  = ((CODE_BITS + 7) / 8) * 8;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [AW-1:0] FREE_INIT = AW'(lbc_pkg::FIRST_FREE);
  localparam logic [EW-1:0] EPOCH_ONE = EW'(1);

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [EW-1:0]        epoch_r, epoch_nxt;
  logic                 clear_pend_r, clear_pend_nxt;
  logic [CODE_BITS-1:0] prefix_r, prefix_nxt;
  logic                 pvalid_r, pvalid_nxt;
  logic [AW-1:0]        next_free_r, next_free_nxt;
  logic [BW-1:0]        byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [CODE_BITS-1:0] e0_code_r, e0_code_nxt, e1_code_r, e1_code_nxt;
  logic                 e0_last_r, e0_last_nxt, e1_last_r, e1_last_nxt;
  logic [1:0]           e_cnt_r, e_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] out_code_r, out_code_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]    ram_wdata, ram_rdata;

  logic [EW-1:0]        slot_epoch;
  logic [CODE_BITS-1:0] slot_prefix, slot_code;
  logic [BW-1:0]        slot_byte;
  logic                 slot_live, slot_hit, push;

  function automatic logic [AW-1:0] slot_hash(input logic [CODE_BITS-1:0] p,
                                               input logic [BW-1:0] b);
    slot_hash = {1'b0, p} ^ {b, {(AW-BW){1'b0}}};
  endfunction

  assign slot_code   = ram_rdata[CODE_BITS-1:0];
  assign slot_byte   = ram_rdata[CODE_BITS+BW-1:CODE_BITS];
  assign slot_prefix = ram_rdata[2*CODE_BITS+BW-1:CODE_BITS+BW];
  assign slot_epoch  = ram_rdata[SLOT_W-1:2*CODE_BITS+BW];
  assign slot_live   = (slot_epoch == epoch_r);
  assign slot_hit    = slot_live && (slot_prefix == prefix_r) && (slot_byte == byte_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign push       = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_code_r);
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    clear_pend_nxt = clear_pend_r;
    prefix_nxt     = prefix_r;
    pvalid_nxt     = pvalid_r;
    next_free_nxt  = next_free_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    addr_nxt       = addr_r;
    e0_code_nxt    = e0_code_r;
    e0_last_nxt    = e0_last_r;
    e1_code_nxt    = e1_code_r;
    e1_last_nxt    = e1_last_r;
    e_cnt_nxt      = e_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = {EW'(epoch_r), prefix_r, byte_r, next_free_r[CODE_BITS-1:0]};
    ram_raddr      = addr_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == {AW{1'b1}}) begin
          epoch_nxt      = EPOCH_ONE;
          clear_pend_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = slot_hash(prefix_r, in_tdata);
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (pvalid_r) begin
            addr_nxt  = ram_raddr;
            state_nxt = ST_CMP;
          end else if (in_tlast) begin
            e0_code_nxt = CODE_BITS'(in_tdata);
            e0_last_nxt = 1'b1;
            e_cnt_nxt   = 2'd1;
            state_nxt   = ST_EMIT;
          end else begin
            prefix_nxt = CODE_BITS'(in_tdata);
            pvalid_nxt = 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (slot_hit) begin
          if (last_r) begin
            e0_code_nxt = slot_code;
            e0_last_nxt = 1'b1;
            e_cnt_nxt   = 2'd1;
            state_nxt   = ST_EMIT;
          end else begin
            prefix_nxt = slot_code;
            state_nxt  = ST_IDLE;
          end
        end else if (slot_live) begin
          // advance to the next slot on a collision
          ram_raddr = addr_r + AW'(1);
          addr_nxt  = ram_raddr;
        end else begin
          if (!next_free_r[CODE_BITS]) begin
            ram_we        = 1'b1;
            next_free_nxt = next_free_r + AW'(1);
          end
          e0_code_nxt = prefix_r;
          e0_last_nxt = 1'b0;
          e1_code_nxt = CODE_BITS'(byte_r);
          e1_last_nxt = 1'b1;
          e_cnt_nxt   = last_r ? 2'd2 : 2'd1;
          prefix_nxt  = CODE_BITS'(byte_r);
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (push) begin
          e0_code_nxt = e1_code_r;
          e0_last_nxt = e1_last_r;
          e_cnt_nxt   = e_cnt_r - 2'd1;
          if (e_cnt_r == 2'd1) begin
            clr_addr_nxt = '0;
            state_nxt    = clear_pend_r ? ST_CLEAR : ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // close the stream: fresh dictionary through a new epoch, or a clearing pass once the epochs run out
    if ((state_r != ST_EMIT) && (state_nxt == ST_EMIT) && last_nxt) begin
      pvalid_nxt    = 1'b0;
      prefix_nxt    = '0;
      next_free_nxt = FREE_INIT;
      if (epoch_r == {EW{1'b1}}) begin
        clear_pend_nxt = 1'b1;
      end else begin
        epoch_nxt = epoch_r + EPOCH_ONE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = e0_code_r;
      out_last_nxt  = e0_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      epoch_r      <= EPOCH_ONE;
      clear_pend_r <= 1'b0;
      prefix_r     <= '0;
      pvalid_r     <= 1'b0;
      next_free_r  <= FREE_INIT;
      e_cnt_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      clear_pend_r <= clear_pend_nxt;
      prefix_r     <= prefix_nxt;
      pvalid_r     <= pvalid_nxt;
      next_free_r  <= next_free_nxt;
      e_cnt_r      <= e_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    addr_r     <= addr_nxt;
    e0_code_r  <= e0_code_nxt;
    e0_last_r  <= e0_last_nxt;
    e1_code_r  <= e1_code_nxt;
    e1_last_r  <= e1_last_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  lbc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/lbc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on lbc_pkg for default sizes.
module lbc_ram #(
  parameter int WIDTH = lbc_pkg::CODE_BITS_DEF,
  parameter int DEPTH = 1 << (lbc_pkg::CODE_BITS_DEF + 1)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lbc_chk.sv */
// Port-level checker for the LZW byte compressor, bound to the top level.
// Depends on lbc_pkg and lzw_byte_compressor_core.
module lbc_chk #(
  parameter int CODE_BITS = lbc_pkg::CODE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [((CODE_BITS+7)/8)*8-1:0] out_tdata,
  input logic                           out_tlast
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("final byte did not hold off the next request");

  a_code_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata >> CODE_BITS) == '0))
    else $error("padding bits of out_tdata not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind lzw_byte_compressor_core lbc_chk #(
  .CODE_BITS (CODE_BITS)
) u_lbc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
